/* sv/iwn_pkg.sv */
package iwn_pkg;

    // stream payload widths
    localparam int unsigned YEAR_W  = 12;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned DAY_W   = 5;
    localparam int unsigned WEEK_W  = 6;
    localparam int unsigned YDAY_W  = 9;
    localparam int unsigned S_TDATA_W = 24;
    localparam int unsigned M_TDATA_W = 8;

    // calendar constants
    localparam logic [YEAR_W-1:0]  EPOCH_YEAR  = 12'd1970;
    localparam logic [WEEK_W-1:0]  WEEK_MAX    = 6'd53;
    localparam logic [MONTH_W-1:0] MONTH_JAN   = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB   = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC   = 4'd12;
    localparam logic [2:0]         WDAY_SUN    = 3'd0;
    localparam logic [2:0]         WDAY_THU    = 3'd4;
    localparam logic [2:0]         WDAY_FRI    = 3'd5;

    // reciprocals: x/100 = (x*5243)>>19 for x < 4096, x/7 = (x*293)>>11 for x < 512
    localparam logic [12:0] RCP_100   = 13'd5243;
    localparam int unsigned RCP_100_SH = 19;
    localparam logic [8:0]  RCP_7     = 9'd293;
    localparam int unsigned RCP_7_SH  = 11;

    typedef logic [YEAR_W-1:0] t_year;
    typedef logic [YDAY_W-1:0] t_yday;
    typedef logic [2:0]        t_wday;

    // zero-based day of year of the first of the month, non-leap
    function automatic t_yday month_start(input logic [MONTH_W-1:0] m);
        t_yday r;
        case (m)
            4'd1:    r = 9'd0;
            4'd2:    r = 9'd31;
            4'd3:    r = 9'd59;
            4'd4:    r = 9'd90;
            4'd5:    r = 9'd120;
            4'd6:    r = 9'd151;
            4'd7:    r = 9'd181;
            4'd8:    r = 9'd212;
            4'd9:    r = 9'd243;
            4'd10:   r = 9'd273;
            4'd11:   r = 9'd304;
            4'd12:   r = 9'd334;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    // days in month, february as 28
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] r;
        case (m)
            4'd2:                      r = 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   r = 5'd30;
            4'd1, 4'd3, 4'd5, 4'd7,
            4'd8, 4'd10, 4'd12:        r = 5'd31;
            default:                   r = 5'd0;
        endcase
        return r;
    endfunction

    // value mod 7 by summing octal digits (8 = 1 mod 7)
    function automatic t_wday mod7_13(input logic [12:0] v);
        logic [4:0] f1;
        logic [3:0] f2;
        f1 = 5'(v[2:0]) + 5'(v[5:3]) + 5'(v[8:6]) + 5'(v[11:9]) + 5'(v[12]);
        f2 = 4'(f1[2:0]) + 4'(f1[4:3]);
        return (f2 >= 4'd7) ? 3'(f2 - 4'd7) : f2[2:0];
    endfunction

    // weekday 0 = sunday .. 6 as iso 1 = monday .. 7 = sunday
    function automatic logic [2:0] iso_wday(input t_wday w);
        return (w == WDAY_SUN) ? 3'd7 : w;
    endfunction

endpackage

/* sv/iso_week_number.sv */
// channel    dir  tdata (low bit up)                              tuser
// s (date)   in   [11:0] year, [15:12] month, [20:16] day_of_month  -
// m (week)   out  [5:0] week                                       [0] date_invalid
//
// six register stages; a date enters every cycle unless a stalled output holds a full pipe
// the stages split the chain year/100, leap rule, two mod 7 folds, /7 and the fixups
// each stage moves on when it is empty or the stage after it moves, so bubbles fill in
// a stalled output holds its transfer while earlier stages with bubbles keep taking dates
// synchronous active-low reset clears only the stage valid bits
module iso_week_number
    import iwn_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [S_TDATA_W-1:0]  i_s_tdata,   // year[11:0], month[15:12], day_of_month[20:16]
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [M_TDATA_W-1:0]  o_m_tdata,   // week[5:0]
    output logic                  o_m_tuser    // date_invalid[0]
);

    localparam int unsigned NSTG = 6;

    // input fields
    t_year                in_year;
    logic [MONTH_W-1:0]   in_month;
    logic [DAY_W-1:0]     in_day;
    assign in_year  = i_s_tdata[11:0];
    assign in_month = i_s_tdata[15:12];
    assign in_day   = i_s_tdata[20:16];

    // stage valids and advance chain
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] adv;

    always_comb begin
        adv[NSTG-1] = !r_vld[NSTG-1] || i_m_tready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            adv[k] = !r_vld[k] || adv[k+1];
        end
    end

    assign o_s_tready = adv[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (adv[0]) begin
                r_vld[0] <= i_s_tvalid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // ---------------- stage 1: year / 100 for both year and year - 1
    t_year              r1_year;
    logic [MONTH_W-1:0] r1_month;
    logic [DAY_W-1:0]   r1_day;
    logic [5:0]         r1_qy;
    logic [5:0]         r1_qa;
    logic               r1_ge;
    logic               r1_first;
    logic [24:0]        prod_y;
    logic [24:0]        prod_a;

    assign prod_y = 25'(in_year) * 25'(RCP_100);
    assign prod_a = 25'(in_year - 12'd1) * 25'(RCP_100);

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r1_year  <= in_year;
            r1_month <= in_month;
            r1_day   <= in_day;
            r1_qy    <= 6'(prod_y >> RCP_100_SH);
            r1_qa    <= 6'(prod_a >> RCP_100_SH);
            r1_ge    <= in_year >= EPOCH_YEAR;
            r1_first <= in_year == EPOCH_YEAR;
        end
    end

    // ---------------- stage 2: leap rule, day of year, validity, jan 1 day count
    t_year       s2_a;
    t_year       s2_ry;
    t_year       s2_ra;
    logic        s2_leap;
    logic        s2_leapp;
    logic [9:0]  s2_lp;
    logic [4:0]  s2_len;
    logic        s2_bad;

    always_comb begin
        s2_a     = r1_year - 12'd1;
        s2_ry    = r1_year - 12'(r1_qy) * 12'd100;
        s2_ra    = s2_a - 12'(r1_qa) * 12'd100;
        s2_leap  = (r1_year[1:0] == 2'd0 && s2_ry != '0) || (s2_ry == '0 && r1_qy[1:0] == 2'd0);
        s2_leapp = (s2_a[1:0] == 2'd0 && s2_ra != '0) || (s2_ra == '0 && r1_qa[1:0] == 2'd0);
        // leap days through year - 1
        s2_lp    = 10'(s2_a >> 2) - 10'(r1_qa) + 10'(r1_qa >> 2);
        s2_len   = month_len(r1_month) + 5'((r1_month == MONTH_FEB) && s2_leap);
        s2_bad   = (r1_month < MONTH_JAN) || (r1_month > MONTH_DEC) || (r1_day == '0)
                   || (r1_day > s2_len);
    end

    logic        r2_leap;
    logic        r2_leapp;
    logic [12:0] r2_sum;
    t_yday       r2_yday;
    logic        r2_bad;
    logic        r2_ge;
    logic        r2_first;

    always_ff @(posedge i_clk) begin
        if (adv[1]) begin
            r2_leap  <= s2_leap;
            r2_leapp <= s2_leapp;
            // 1970 + leaps through 1969 is 4 mod 7, the same as the thursday epoch,
            // so this sum mod 7 is jan 1
            r2_sum   <= 13'(r1_year) + 13'(s2_lp);
            r2_yday  <= month_start(r1_month) + 9'(r1_day) - 9'd1
                        + 9'((r1_month > MONTH_FEB) && s2_leap);
            r2_bad   <= s2_bad;
            r2_ge    <= r1_ge;
            r2_first <= r1_first;
        end
    end

    // ---------------- stage 3: weekday of jan 1, day of year mod 7
    t_wday r3_jan1;
    t_wday r3_ydm;
    t_yday r3_yday;
    logic  r3_leap;
    logic  r3_leapp;
    logic  r3_bad;
    logic  r3_ge;
    logic  r3_first;

    always_ff @(posedge i_clk) begin
        if (adv[2]) begin
            r3_jan1  <= mod7_13(r2_sum);
            r3_ydm   <= mod7_13(13'(r2_yday));
            r3_yday  <= r2_yday;
            r3_leap  <= r2_leap;
            r3_leapp <= r2_leapp;
            r3_bad   <= r2_bad;
            r3_ge    <= r2_ge;
            r3_first <= r2_first;
        end
    end

    // ---------------- stage 4: weekdays of the date and both dec 31, week numerators
    logic [3:0] s4_wsum;
    t_wday      s4_wd;
    t_wday      s4_d31;
    t_wday      s4_d31p;

    always_comb begin
        s4_wsum = 4'(r3_jan1) + 4'(r3_ydm);
        s4_wd   = (s4_wsum >= 4'd7) ? 3'(s4_wsum - 4'd7) : s4_wsum[2:0];
        // dec 31 is day 364 + leap, and 364 is 0 mod 7
        s4_d31  = (r3_leap && r3_jan1 == 3'd6) ? WDAY_SUN : r3_jan1 + 3'(r3_leap);
        // dec 31 of last year is the day before jan 1
        s4_d31p = (r3_jan1 == WDAY_SUN) ? 3'd6 : r3_jan1 - 3'd1;
    end

    logic [9:0] r4_num;
    logic [9:0] r4_nump;
    t_wday      r4_d31;
    t_wday      r4_d31p;
    logic       r4_leap;
    logic       r4_leapp;
    logic       r4_bad;
    logic       r4_ge;
    logic       r4_first;

    always_ff @(posedge i_clk) begin
        if (adv[3]) begin
            r4_num   <= 10'(r3_yday) + 10'd11 - 10'(iso_wday(s4_wd));
            r4_nump  <= 10'd375 + 10'(r3_leapp) - 10'(iso_wday(s4_d31p));
            r4_d31   <= s4_d31;
            r4_d31p  <= s4_d31p;
            r4_leap  <= r3_leap;
            r4_leapp <= r3_leapp;
            r4_bad   <= r3_bad;
            r4_ge    <= r3_ge;
            r4_first <= r3_first;
        end
    end

    // ---------------- stage 5: base weeks, divide by 7, week 53 flags
    logic [18:0] prod_w;
    logic [18:0] prod_wp;
    assign prod_w  = 19'(r4_num)  * 19'(RCP_7);
    assign prod_wp = 19'(r4_nump) * 19'(RCP_7);

    logic [WEEK_W-1:0] r5_bw;
    logic [WEEK_W-1:0] r5_bwp;
    logic              r5_w53;
    logic              r5_w53p;
    logic              r5_bad;
    logic              r5_ge;
    logic              r5_first;

    always_ff @(posedge i_clk) begin
        if (adv[4]) begin
            r5_bw    <= 6'(prod_w >> RCP_7_SH);
            r5_bwp   <= 6'(prod_wp >> RCP_7_SH);
            // week 53 holds when dec 31 is a thursday, or a friday in a leap year
            r5_w53   <= (r4_d31 == WDAY_THU) || (r4_d31 == WDAY_FRI && r4_leap);
            r5_w53p  <= (r4_d31p == WDAY_THU) || (r4_d31p == WDAY_FRI && r4_leapp);
            r5_bad   <= r4_bad;
            r5_ge    <= r4_ge;
            r5_first <= r4_first;
        end
    end

    // ---------------- stage 6: week 0 and week 53 fixups, output register
    logic [WEEK_W-1:0] s6_prev;
    logic [WEEK_W-1:0] s6_week;

    always_comb begin
        s6_prev = (r5_bwp == WEEK_MAX) ? (r5_w53p ? WEEK_MAX : 6'd1) : r5_bwp;
        if (r5_bad || !r5_ge) begin
            s6_week = '0;
        end else if (r5_bw == '0) begin
            // early january: week of last dec 31, none before the epoch year
            s6_week = r5_first ? 6'd0 : s6_prev;
        end else if (r5_bw == WEEK_MAX) begin
            s6_week = r5_w53 ? WEEK_MAX : 6'd1;
        end else begin
            s6_week = r5_bw;
        end
    end

    logic [WEEK_W-1:0] r6_week;
    logic              r6_bad;

    always_ff @(posedge i_clk) begin
        if (adv[5]) begin
            r6_week <= s6_week;
            r6_bad  <= r5_bad;
        end
    end

    assign o_m_tvalid = r_vld[NSTG-1];
    assign o_m_tdata  = {2'b00, r6_week};
    assign o_m_tuser  = r6_bad;

endmodule

/* sv/iwn_chk.sv */
module iwn_chk
    import iwn_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_s_tvalid,
    input logic                 o_s_tready,
    input logic [S_TDATA_W-1:0] i_s_tdata,
    input logic                 o_m_tvalid,
    input logic                 i_m_tready,
    input logic [M_TDATA_W-1:0] o_m_tdata,
    input logic                 o_m_tuser
);

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("stalled result changed");

    // an invalid date reports week 0
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> o_m_tdata == '0)
        else $error("invalid date with nonzero week");

    // week within 0..53, pad bits clear
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[5:0] <= WEEK_MAX && o_m_tdata[7:6] == 2'b00)
        else $error("week out of range");

    // pipeline empty right after reset
    a_rst: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_m_tvalid)
        else $error("result valid after reset");

    // an idle output never blocks the input side
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input stalled with empty output");

endmodule

bind iso_week_number iwn_chk u_iwn_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

/* verif/iso_week_number_tb.sv */
module testbench;
    import iwn_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned RANDOM_DATES = 1250;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned DRAIN_CYCLES = 20;
    localparam int unsigned MAX_REPORTS  = 10;

    // zero-based day of year of each month start, and month lengths, non-leap
    localparam int unsigned MONTH_FIRST_YDAY[12] =
        '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
    localparam int unsigned MONTH_DAYS[12] =
        '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic               typed;   // week and bad below are given, not predicted
        logic [WEEK_W-1:0]  week;
        logic               bad;
    } t_date_row;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [WEEK_W-1:0]  week;
        logic               bad;
    } t_week_exp;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;    // year[11:0], month[15:12], day_of_month[20:16]
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;    // week[5:0]
    logic                 m_tuser;    // date_invalid[0]

    t_week_exp   weeks_due[$];
    t_date_row   directed_rows[$];
    t_date_row   cur_row;
    t_week_exp   oldest_week;
    logic [WEEK_W-1:0] pred_week;
    logic        pred_bad;
    int unsigned error_count = 0;
    int unsigned leftover;
    int unsigned hold_requests = 0;
    bit          no_idle = 1'b0;

    iso_week_number u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ---------------- calendar predictor ----------------

    function automatic bit leap_year(input int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int unsigned leaps_up_to(input int unsigned y);
        return y / 4 - y / 100 + y / 400;
    endfunction

    function automatic int unsigned days_in_month(input int unsigned y, input int unsigned m);
        return MONTH_DAYS[m-1] + ((m == MONTH_FEB) ? int'(leap_year(y)) : 0);
    endfunction

    // 0 = sunday .. 6 = saturday, counted from a thursday epoch
    function automatic int unsigned weekday_from_epoch(input int unsigned y,
                                                       input int unsigned yday);
        int unsigned days;
        days = 365 * (y - EPOCH_YEAR) + (leaps_up_to(y - 1) - leaps_up_to(EPOCH_YEAR - 1))
             + yday;
        return (WDAY_THU + days) % 7;
    endfunction

    function automatic int unsigned raw_week(input int unsigned yday, input int unsigned wday);
        int unsigned iso_day;
        iso_day = (wday == WDAY_SUN) ? 7 : wday;
        return (yday + 11 - iso_day) / 7;
    endfunction

    // week 53 survives only when dec 31 is a thursday, or a friday in a leap year
    function automatic int unsigned settle_week53(input int unsigned y);
        int unsigned lp;
        int unsigned last_wday;
        lp = leap_year(y);
        last_wday = weekday_from_epoch(y, 364 + lp);
        if (last_wday == WDAY_THU || (last_wday == WDAY_FRI && lp != 0))
            return WEEK_MAX;
        return 1;
    endfunction

    function automatic int unsigned week_in_year(input int unsigned y, input int unsigned yday);
        int unsigned w;
        int unsigned prev;
        int unsigned prev_last;
        w = raw_week(yday, weekday_from_epoch(y, yday));
        if (w == 0) begin
            // early january belongs to the last week of the year before
            prev = y - 1;
            if (prev < EPOCH_YEAR)
                return 0;
            prev_last = 364 + leap_year(prev);
            w = raw_week(prev_last, weekday_from_epoch(prev, prev_last));
            if (w == WEEK_MAX)
                w = settle_week53(prev);
        end else if (w == WEEK_MAX) begin
            w = settle_week53(y);
        end
        return w;
    endfunction

    task automatic predict_week(input logic [YEAR_W-1:0] y, input logic [MONTH_W-1:0] m,
                                input logic [DAY_W-1:0] d,
                                output logic [WEEK_W-1:0] week, output logic bad);
        int unsigned yday;
        week = '0;
        bad = (m < MONTH_JAN) || (m > MONTH_DEC) || (d == 0);
        if (!bad)
            bad = (d > days_in_month(y, m));
        if (!bad && y >= EPOCH_YEAR) begin
            yday = MONTH_FIRST_YDAY[m-1] + (d - 1) + ((m > MONTH_FEB) ? int'(leap_year(y)) : 0);
            week = WEEK_W'(week_in_year(y, yday));
        end
    endtask

    // ---------------- checker ----------------

    task automatic flag_error(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("%0t: %s", $realtime, msg);
    endtask

    always @(posedge clk) begin
        if (rst_n) begin
            if (m_tvalid && m_tready) begin
                if (weeks_due.size() == 0) begin
                    flag_error($sformatf("unexpected result week=%0d invalid=%0b",
                                         m_tdata[WEEK_W-1:0], m_tuser));
                end else begin
                    oldest_week = weeks_due.pop_front();
                    if (m_tdata[WEEK_W-1:0] !== oldest_week.week || m_tuser !== oldest_week.bad)
                        flag_error($sformatf(
                            "%0d-%0d-%0d: expected week=%0d invalid=%0b, got week=%0d invalid=%0b",
                            oldest_week.year, oldest_week.month, oldest_week.day,
                            oldest_week.week, oldest_week.bad,
                            m_tdata[WEEK_W-1:0], m_tuser));
                end
            end
            if (s_tvalid && s_tready) begin
                if (cur_row.typed) begin
                    pred_week = cur_row.week;
                    pred_bad  = cur_row.bad;
                end else begin
                    predict_week(cur_row.year, cur_row.month, cur_row.day, pred_week, pred_bad);
                end
                weeks_due.push_back('{cur_row.year, cur_row.month, cur_row.day,
                                      pred_week, pred_bad});
            end
        end
    end

    // ---------------- receiver ----------------

    initial begin : receiver
        int unsigned hold_seen;
        int unsigned hold_left;
        hold_seen = 0;
        hold_left = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_requests != hold_seen) begin
                hold_seen = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (!no_idle && $urandom_range(99) < 23) begin
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // ---------------- sender ----------------

    // valid stays high after a transfer until the next negedge drives a new date or a gap
    task automatic send_date(input t_date_row row);
        while (!no_idle && $urandom_range(99) < 23) begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        cur_row = row;
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'({row.day, row.month, row.year});
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // mostly real dates, weighted toward the turn of the year, plus junk fields
    task automatic random_date(output t_date_row row);
        int unsigned pick;
        pick = $urandom_range(99);
        row = '0;
        if (pick < 60) begin
            row.year  = YEAR_W'($urandom_range(2155, EPOCH_YEAR));
            row.month = MONTH_W'($urandom_range(MONTH_DEC, MONTH_JAN));
            row.day   = DAY_W'($urandom_range(days_in_month(row.year, row.month), 1));
        end else if (pick < 78) begin
            row.year = YEAR_W'($urandom_range(2155, EPOCH_YEAR));
            if ($urandom_range(1)) begin
                row.month = MONTH_DEC;
                row.day   = DAY_W'($urandom_range(31, 22));
            end else begin
                row.month = MONTH_JAN;
                row.day   = DAY_W'($urandom_range(10, 1));
            end
        end else if (pick < 88) begin
            row.year  = YEAR_W'($urandom_range(4095));
            row.month = MONTH_W'($urandom_range(MONTH_DEC, MONTH_JAN));
            row.day   = DAY_W'($urandom_range(31, 1));
        end else begin
            row.year  = YEAR_W'($urandom);
            row.month = MONTH_W'($urandom);
            row.day   = DAY_W'($urandom);
        end
    endtask

    initial begin : main
        t_date_row row;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        cur_row  = '0;

        // dates with a fixed answer carry it, the rest go through the predictor
        directed_rows.push_back('{12'd1970, 4'd1,  5'd1,  1'b1, 6'd1, 1'b0});
        directed_rows.push_back('{12'd1969, 4'd12, 5'd31, 1'b1, 6'd0, 1'b0});
        directed_rows.push_back('{12'd1900, 4'd1,  5'd1,  1'b1, 6'd0, 1'b0});
        directed_rows.push_back('{12'd0,    4'd1,  5'd1,  1'b1, 6'd0, 1'b0});
        directed_rows.push_back('{12'd2020, 4'd0,  5'd10, 1'b1, 6'd0, 1'b1});
        directed_rows.push_back('{12'd2020, 4'd13, 5'd10, 1'b1, 6'd0, 1'b1});
        directed_rows.push_back('{12'd4095, 4'd15, 5'd31, 1'b1, 6'd0, 1'b1});
        directed_rows.push_back('{12'd2020, 4'd6,  5'd0,  1'b1, 6'd0, 1'b1});
        directed_rows.push_back('{12'd2021, 4'd2,  5'd29, 1'b1, 6'd0, 1'b1});
        directed_rows.push_back('{12'd1900, 4'd2,  5'd29, 1'b1, 6'd0, 1'b1});
        directed_rows.push_back('{12'd2100, 4'd2,  5'd29, 1'b1, 6'd0, 1'b1});
        directed_rows.push_back('{12'd2023, 4'd4,  5'd31, 1'b1, 6'd0, 1'b1});
        directed_rows.push_back('{12'd2020, 4'd2,  5'd29, 1'b0, 6'd0, 1'b0});
        directed_rows.push_back('{12'd2000, 4'd2,  5'd29, 1'b0, 6'd0, 1'b0});
        directed_rows.push_back('{12'd1971, 4'd1,  5'd1,  1'b0, 6'd0, 1'b0});
        directed_rows.push_back('{12'd2021, 4'd1,  5'd1,  1'b0, 6'd0, 1'b0});
        directed_rows.push_back('{12'd2005, 4'd1,  5'd1,  1'b0, 6'd0, 1'b0});
        directed_rows.push_back('{12'd2024, 4'd12, 5'd30, 1'b0, 6'd0, 1'b0});
        directed_rows.push_back('{12'd2019, 4'd12, 5'd31, 1'b0, 6'd0, 1'b0});
        directed_rows.push_back('{12'd2020, 4'd12, 5'd31, 1'b0, 6'd0, 1'b0});
        directed_rows.push_back('{12'd2004, 4'd12, 5'd31, 1'b0, 6'd0, 1'b0});
        directed_rows.push_back('{12'd2015, 4'd12, 5'd31, 1'b0, 6'd0, 1'b0});
        directed_rows.push_back('{12'd2155, 4'd12, 5'd31, 1'b0, 6'd0, 1'b0});
        directed_rows.push_back('{12'd4095, 4'd12, 5'd31, 1'b0, 6'd0, 1'b0});
        directed_rows.push_back('{12'd1970, 4'd1,  5'd31, 1'b0, 6'd0, 1'b0});

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_date(directed_rows[i]);

        for (int n = 0; n < RANDOM_DATES; n++) begin
            // long output stall while dates keep coming, so the pipe backs up
            if (n == 300)
                hold_requests++;
            // sender pause until the pipe has drained, with valid dropped first
            if (n == 600) begin
                @(negedge clk);
                s_tvalid <= 1'b0;
                while (weeks_due.size() != 0)
                    @(posedge clk);
            end
            no_idle = (n >= 800 && n < 1000);
            random_date(row);
            send_date(row);
        end
        @(negedge clk);
        s_tvalid <= 1'b0;

        while (weeks_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        leftover = weeks_due.size();

        if (error_count == 0 && leftover == 0) begin
            $display("iso_week_number test passed");
        end else begin
            $display("iso_week_number test failed");
        end
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("iso_week_number test failed");
        $finish;
    end

endmodule

/* filelist.f */
sv/iwn_pkg.sv
sv/iso_week_number.sv
sv/iwn_chk.sv
verif/iso_week_number_tb.sv
